// File: sv/sgi_pkg.sv
`timescale 1ns / 1ps
package sgi_pkg;

   typedef struct packed {
      logic valid;
      logic hit;
      logic parallel;
   } sgi_ctl_type;

endpackage

// File: sv/segment_intersection_2d.sv
`timescale 1ns / 1ps
// channel   ports                                      role
// req       req_valid, req_stall, req_a_*, req_b_*     segment pair in
// rsp       rsp_valid, rsp_stall, rsp_hit, rsp_parallel,
//           rsp_cross_x, rsp_cross_y                   test result out
//
// One beat per cycle unless rsp_stall holds a result; five front stages
// (differences, products, cross products, sign fold, hit and numerator
// product), one restoring divide stage per quotient bit, one output stage.
// Synchronous active-high reset clears all valid bits.
// Whole pipeline holds while a result waits under rsp_stall; req_stall
// follows that hold.
module segment_intersection_2d
   import sgi_pkg::*;
#(
   parameter int COORD_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [COORD_WIDTH-1:0]  req_a_start_x,
   input  logic signed [COORD_WIDTH-1:0]  req_a_start_y,
   input  logic signed [COORD_WIDTH-1:0]  req_a_end_x,
   input  logic signed [COORD_WIDTH-1:0]  req_a_end_y,
   input  logic signed [COORD_WIDTH-1:0]  req_b_start_x,
   input  logic signed [COORD_WIDTH-1:0]  req_b_start_y,
   input  logic signed [COORD_WIDTH-1:0]  req_b_end_x,
   input  logic signed [COORD_WIDTH-1:0]  req_b_end_y,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_hit,
   output logic                           rsp_parallel,
   output logic signed [COORD_WIDTH-1:0]  rsp_cross_x,
   output logic signed [COORD_WIDTH-1:0]  rsp_cross_y
);

   localparam int CW = COORD_WIDTH;
   localparam int QW = CW + 1;
   localparam int NW = 3 * CW + 4;
   localparam int DW = 2 * CW + 3;

   logic ce;
   sgi_ctl_type ctl [QW:0];
   logic [NW-1:0] rx [QW:0];
   logic [NW-1:0] ry [QW:0];
   logic [QW-1:0] qx [QW:0];
   logic [QW-1:0] qy [QW:0];
   logic [DW-1:0] dn [QW:0];
   logic signed [CW-1:0] sx [QW:0];
   logic signed [CW-1:0] sy [QW:0];
   logic nx [QW:0];
   logic ny [QW:0];

   logic valid_ff, hit_ff, par_ff;
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic signed [CW+1:0] cx_in, cy_in;

   assign ce = !(valid_ff && rsp_stall);
   assign req_stall = !ce;

   sgi_front #(.CW(CW)) u_front (
      .clock(clock), .reset(reset), .ce(ce), .in_valid(req_valid),
      .a_start_x(req_a_start_x), .a_start_y(req_a_start_y),
      .a_end_x(req_a_end_x), .a_end_y(req_a_end_y),
      .b_start_x(req_b_start_x), .b_start_y(req_b_start_y),
      .b_end_x(req_b_end_x), .b_end_y(req_b_end_y),
      .ctl(ctl[0]), .num_x(rx[0]), .num_y(ry[0]), .den(dn[0]),
      .start_x(sx[0]), .start_y(sy[0]), .neg_x(nx[0]), .neg_y(ny[0])
   );

   assign qx[0] = '0;
   assign qy[0] = '0;

   for (genvar g = 0; g < QW; g++) begin : g_div
      sgi_div_stage #(.CW(CW), .SHIFT(QW - 1 - g)) u_stage (
         .clock(clock), .reset(reset), .ce(ce),
         .ctl_i(ctl[g]), .rx_i(rx[g]), .ry_i(ry[g]), .qx_i(qx[g]), .qy_i(qy[g]),
         .den_i(dn[g]), .sx_i(sx[g]), .sy_i(sy[g]), .nx_i(nx[g]), .ny_i(ny[g]),
         .ctl_o(ctl[g+1]), .rx_o(rx[g+1]), .ry_o(ry[g+1]), .qx_o(qx[g+1]),
         .qy_o(qy[g+1]), .den_o(dn[g+1]), .sx_o(sx[g+1]), .sy_o(sy[g+1]),
         .nx_o(nx[g+1]), .ny_o(ny[g+1])
      );
   end

   assign cx_in = nx[QW] ? (CW+2)'(sx[QW]) - (CW+2)'(qx[QW])
                         : (CW+2)'(sx[QW]) + (CW+2)'(qx[QW]);
   assign cy_in = ny[QW] ? (CW+2)'(sy[QW]) - (CW+2)'(qy[QW])
                         : (CW+2)'(sy[QW]) + (CW+2)'(qy[QW]);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ce) begin
         valid_ff <= ctl[QW].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         hit_ff <= ctl[QW].hit;
         par_ff <= ctl[QW].parallel;
         cx_ff <= ctl[QW].hit ? cx_in[CW-1:0] : '0;
         cy_ff <= ctl[QW].hit ? cy_in[CW-1:0] : '0;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_hit = hit_ff;
   assign rsp_parallel = par_ff;
   assign rsp_cross_x = cx_ff;
   assign rsp_cross_y = cy_ff;

`ifndef SYNTH
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_cross_x == '0 && rsp_cross_y == '0))
      else $error("miss with nonzero point");
   a_par_nohit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_parallel) |-> !rsp_hit)
      else $error("parallel beat flagged as hit");
   a_hold_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input held without output backpressure");
`endif

endmodule

// File: sv/sgi_front.sv
`timescale 1ns / 1ps
module sgi_front
   import sgi_pkg::*;
#(
   parameter int CW = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        ce,
   input  logic                        in_valid,
   input  logic signed [CW-1:0]        a_start_x,
   input  logic signed [CW-1:0]        a_start_y,
   input  logic signed [CW-1:0]        a_end_x,
   input  logic signed [CW-1:0]        a_end_y,
   input  logic signed [CW-1:0]        b_start_x,
   input  logic signed [CW-1:0]        b_start_y,
   input  logic signed [CW-1:0]        b_end_x,
   input  logic signed [CW-1:0]        b_end_y,
   output sgi_ctl_type                 ctl,
   output logic [2*CW+3+CW:0]          num_x,
   output logic [2*CW+3+CW:0]          num_y,
   output logic [2*CW+2:0]             den,
   output logic signed [CW-1:0]        start_x,
   output logic signed [CW-1:0]        start_y,
   output logic                        neg_x,
   output logic                        neg_y
);

   localparam int EW = CW + 1;
   localparam int PW = 2 * EW;
   localparam int DW = PW + 1;
   localparam int QW = CW + 1;
   localparam int NW = DW + QW;

   // stage 1: differences
   logic [4:0] v_ff;
   logic signed [EW-1:0] s1x_ff, s1y_ff, s2x_ff, s2y_ff, ux_ff, uy_ff;
   logic signed [EW-1:0] s1x2_ff, s1y2_ff, s1x3_ff, s1y3_ff, s1x4_ff, s1y4_ff;
   logic signed [CW-1:0] p0x_ff [4:0];
   logic signed [CW-1:0] p0y_ff [4:0];
   // stage 2: products
   logic signed [PW-1:0] dna_ff, dnb_ff, sna_ff, snb_ff, tna_ff, tnb_ff;
   // stage 3: cross products
   logic signed [DW-1:0] dn3_ff, sn3_ff, tn3_ff;
   // stage 4: sign normalized
   logic signed [DW-1:0] dn4_ff, sn4_ff, tn4_ff;
   logic [EW-1:0] magx4_ff, magy4_ff;
   logic par4_ff;
   // stage 5
   sgi_ctl_type ctl_ff;
   logic [NW-1:0] numx_ff, numy_ff;
   logic [DW-1:0] dn5_ff;
   logic negx_ff, negy_ff;

   logic signed [DW-1:0] dn3_in, sn3_in, tn3_in;
   logic signed [DW-1:0] dn4_in, sn4_in, tn4_in;
   logic hit5_in;

   assign dn3_in = DW'(dna_ff) - DW'(dnb_ff);
   assign sn3_in = DW'(sna_ff) - DW'(snb_ff);
   assign tn3_in = DW'(tna_ff) - DW'(tnb_ff);
   assign dn4_in = dn3_ff[DW-1] ? -dn3_ff : dn3_ff;
   assign sn4_in = dn3_ff[DW-1] ? -sn3_ff : sn3_ff;
   assign tn4_in = dn3_ff[DW-1] ? -tn3_ff : tn3_ff;
   assign hit5_in = !par4_ff && !sn4_ff[DW-1] && (sn4_ff <= dn4_ff)
                    && !tn4_ff[DW-1] && (tn4_ff <= dn4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
         ctl_ff <= '0;
      end else if (ce) begin
         v_ff <= {v_ff[3:0], in_valid};
         ctl_ff.valid <= v_ff[3];
         ctl_ff.hit <= hit5_in;
         ctl_ff.parallel <= par4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s1x_ff <= EW'(a_end_x) - EW'(a_start_x);
         s1y_ff <= EW'(a_end_y) - EW'(a_start_y);
         s2x_ff <= EW'(b_end_x) - EW'(b_start_x);
         s2y_ff <= EW'(b_end_y) - EW'(b_start_y);
         ux_ff <= EW'(a_start_x) - EW'(b_start_x);
         uy_ff <= EW'(a_start_y) - EW'(b_start_y);
         p0x_ff[0] <= a_start_x;
         p0y_ff[0] <= a_start_y;
         for (int i = 1; i < 5; i++) begin
            p0x_ff[i] <= p0x_ff[i-1];
            p0y_ff[i] <= p0y_ff[i-1];
         end

         dna_ff <= s1x_ff * s2y_ff;
         dnb_ff <= s2x_ff * s1y_ff;
         sna_ff <= s1x_ff * uy_ff;
         snb_ff <= s1y_ff * ux_ff;
         tna_ff <= s2x_ff * uy_ff;
         tnb_ff <= s2y_ff * ux_ff;
         s1x2_ff <= s1x_ff;
         s1y2_ff <= s1y_ff;

         dn3_ff <= dn3_in;
         sn3_ff <= sn3_in;
         tn3_ff <= tn3_in;
         s1x3_ff <= s1x2_ff;
         s1y3_ff <= s1y2_ff;

         dn4_ff <= dn4_in;
         sn4_ff <= sn4_in;
         tn4_ff <= tn4_in;
         par4_ff <= (dn3_ff == '0);
         magx4_ff <= s1x3_ff[EW-1] ? EW'(-s1x3_ff) : EW'(s1x3_ff);
         magy4_ff <= s1y3_ff[EW-1] ? EW'(-s1y3_ff) : EW'(s1y3_ff);
         s1x4_ff <= s1x3_ff;
         s1y4_ff <= s1y3_ff;

         numx_ff <= NW'(tn4_ff[DW-2:0]) * NW'(magx4_ff);
         numy_ff <= NW'(tn4_ff[DW-2:0]) * NW'(magy4_ff);
         dn5_ff <= dn4_ff;
         negx_ff <= s1x4_ff[EW-1];
         negy_ff <= s1y4_ff[EW-1];
      end
   end

   assign ctl = ctl_ff;
   assign num_x = numx_ff;
   assign num_y = numy_ff;
   assign den = dn5_ff;
   assign start_x = p0x_ff[4];
   assign start_y = p0y_ff[4];
   assign neg_x = negx_ff;
   assign neg_y = negy_ff;

endmodule

// File: sv/sgi_div_stage.sv
`timescale 1ns / 1ps
module sgi_div_stage
   import sgi_pkg::*;
#(
   parameter int CW = 16,
   parameter int SHIFT = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   ce,
   input  sgi_ctl_type            ctl_i,
   input  logic [3*CW+3:0]        rx_i,
   input  logic [3*CW+3:0]        ry_i,
   input  logic [CW:0]            qx_i,
   input  logic [CW:0]            qy_i,
   input  logic [2*CW+2:0]        den_i,
   input  logic signed [CW-1:0]   sx_i,
   input  logic signed [CW-1:0]   sy_i,
   input  logic                   nx_i,
   input  logic                   ny_i,
   output sgi_ctl_type            ctl_o,
   output logic [3*CW+3:0]        rx_o,
   output logic [3*CW+3:0]        ry_o,
   output logic [CW:0]            qx_o,
   output logic [CW:0]            qy_o,
   output logic [2*CW+2:0]        den_o,
   output logic signed [CW-1:0]   sx_o,
   output logic signed [CW-1:0]   sy_o,
   output logic                   nx_o,
   output logic                   ny_o
);

   localparam int NW = 3 * CW + 4;
   localparam int QW = CW + 1;

   sgi_ctl_type ctl_ff;
   logic [NW-1:0] rx_ff, ry_ff, dsh;
   logic [QW-1:0] qx_ff, qy_ff;
   logic [2*CW+2:0] den_ff;
   logic signed [CW-1:0] sx_ff, sy_ff;
   logic nx_ff, ny_ff, gex, gey;

   assign dsh = NW'(den_i) << SHIFT;
   assign gex = rx_i >= dsh;
   assign gey = ry_i >= dsh;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (ce) begin
         ctl_ff <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rx_ff <= gex ? rx_i - dsh : rx_i;
         ry_ff <= gey ? ry_i - dsh : ry_i;
         qx_ff <= qx_i | (QW'(gex) << SHIFT);
         qy_ff <= qy_i | (QW'(gey) << SHIFT);
         den_ff <= den_i;
         sx_ff <= sx_i;
         sy_ff <= sy_i;
         nx_ff <= nx_i;
         ny_ff <= ny_i;
      end
   end

   assign ctl_o = ctl_ff;
   assign rx_o = rx_ff;
   assign ry_o = ry_ff;
   assign qx_o = qx_ff;
   assign qy_o = qy_ff;
   assign den_o = den_ff;
   assign sx_o = sx_ff;
   assign sy_o = sy_ff;
   assign nx_o = nx_ff;
   assign ny_o = ny_ff;

endmodule
